### rtl/hsnr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsnr_pkg
// Shared types and constants for the two-dimensional harmonic sum block.
// ----------------------------------------------------------------------------
package hsnr_pkg;

	localparam int STORE_DEPTH = 4096;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int LIM_W       = ADDR_W + 1;
	localparam int MAX_LEVELS  = 8;
	localparam int LVL_W       = $clog2(MAX_LEVELS);
	localparam int LCNT_W      = LVL_W + 1;
	localparam int CELL_AW     = 1 + 2 * LVL_W;
	localparam int CELL_DEPTH  = 2 ** CELL_AW;
	localparam int SMP_W       = 16;
	localparam int SUM_W       = 24;
	localparam int SPR_W       = 23;
	localparam int CFG_W       = 13;
	localparam int IDX_W       = 12;
	localparam int BASE_W      = 16;
	localparam int ROFF_W      = 17;
	localparam int AOFF_W      = 18;
	localparam int DIFF_W      = SUM_W + 1;
	localparam int NUM_W       = DIFF_W + 8;
	localparam int DIV_STEPS   = NUM_W;
	localparam int DCNT_W      = $clog2(DIV_STEPS);

	localparam logic [1:0] CMD_SAMPLE = 2'd0;
	localparam logic [1:0] CMD_STATS  = 2'd1;
	localparam logic [1:0] CMD_QUERY  = 2'd2;

	localparam logic [1:0] CFG_ROW_LENGTH = 2'd0;
	localparam logic [1:0] CFG_ROW_COUNT  = 2'd1;
	localparam logic [1:0] CFG_HARM_COUNT = 2'd2;

	localparam logic signed [SUM_W-1:0] SAT_MAX = 24'sh7FFFFF;
	localparam logic signed [SUM_W-1:0] SAT_MIN = 24'sh800000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_CELL0,
		ST_CELL1,
		ST_CELL2,
		ST_DIV0,
		ST_DIV,
		ST_NORM,
		ST_DONE
	} hsnr_state_t;

	// controller to datapath
	typedef struct packed {
		logic              wr_sample;
		logic              wr_stats;
		logic              q_accept;
		logic              q_init;
		logic              cell_issue;
		logic              pair_b;
		logic              cell_fin;
		logic              step_b;
		logic              step_a;
		logic              lvl_next;
		logic              div_init;
		logic              div_step;
		logic              norm;
		logic [LVL_W-1:0]  lvl;
		logic [LVL_W-1:0]  a;
		logic [LVL_W-1:0]  b;
	} hsnr_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [LCNT_W-1:0] levels;
	} hsnr_stat_t;

endpackage

`default_nettype wire

### rtl/two_d_harmonic_sum_snr.sv
`timescale 1ns / 1ps
`default_nettype none
// Loads are taken while idle and do not raise busy. A query walks every level:
// each cell of the level, then the bit-serial divider; with no levels it goes
// straight to the result. A cell reads its parents as two pairs from the sum
// bank. One query at a time; busy is high meanwhile.
// The result strobe done lasts one cycle; the receiver cannot stall it.
// Reset clears control and configuration; stores are undefined until written.
// ----------------------------------------------------------------------------
// two_d_harmonic_sum_snr
// Two-dimensional harmonic sum with per-level signal-to-noise normalisation.
// ----------------------------------------------------------------------------
module two_d_harmonic_sum_snr
	import hsnr_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic [1:0]               cmd,
	input  wire logic [IDX_W-1:0]         index,
	input  wire logic signed [SMP_W-1:0]  sample,
	input  wire logic signed [SUM_W-1:0]  mean,
	input  wire logic [SPR_W-1:0]         spread,
	output logic                          done,
	output logic signed [SUM_W-1:0]       snr,
	output logic [LVL_W-1:0]              best_harmonic,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [1:0]               cfg_index,
	input  wire logic [CFG_W-1:0]         cfg_data
);

	hsnr_cmd_t  ctl;
	hsnr_stat_t stat;

	// configuration beats are always taken
	assign cfg_ready = 1'b1;

	hsnr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	hsnr_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.stat          (stat),
		.index         (index),
		.sample        (sample),
		.mean          (mean),
		.spread        (spread),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.snr           (snr),
		.best_harmonic (best_harmonic)
	);

endmodule

`default_nettype wire

### rtl/hsnr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsnr_ctrl
// Sequencer: walks levels and cells of a query, then the divider per level.
// ----------------------------------------------------------------------------
module hsnr_ctrl
	import hsnr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [1:0] cmd,
	input  wire hsnr_stat_t stat,
	output hsnr_cmd_t       ctl,
	output logic            busy,
	output logic            done
);

	hsnr_state_t       state_q, state_d;
	logic [LVL_W-1:0]  lvl_q, a_q, b_q;
	logic [DCNT_W-1:0] div_cnt_q;
	logic              last_lvl, last_b, last_a, accept;

	assign accept   = start && (state_q == ST_IDLE);
	assign last_lvl = ({1'b0, lvl_q} == (stat.levels - LCNT_W'(1)));
	assign last_b   = (b_q == lvl_q);
	assign last_a   = (a_q == lvl_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (cmd == CMD_QUERY)) state_d = ST_PREP;
			end
			ST_PREP: begin
				if (stat.levels == '0) state_d = ST_DONE;
				else state_d = ST_CELL0;
			end
			ST_CELL0: state_d = ST_CELL1;
			ST_CELL1: state_d = ST_CELL2;
			ST_CELL2: begin
				if (last_a && last_b) state_d = ST_DIV0;
				else state_d = ST_CELL0;
			end
			ST_DIV0:  state_d = ST_DIV;
			ST_DIV: begin
				if (div_cnt_q == DCNT_W'(DIV_STEPS - 1)) state_d = ST_NORM;
			end
			ST_NORM: begin
				if (last_lvl) state_d = ST_DONE;
				else state_d = ST_CELL0;
			end
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// state and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			lvl_q     <= '0;
			a_q       <= '0;
			b_q       <= '0;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_PREP: begin
					lvl_q <= '0;
					a_q   <= '0;
					b_q   <= '0;
				end
				ST_CELL2: begin
					if (!last_b) begin
						b_q <= b_q + LVL_W'(1);
					end else if (!last_a) begin
						b_q <= '0;
						a_q <= a_q + LVL_W'(1);
					end
				end
				ST_DIV0: div_cnt_q <= '0;
				ST_DIV:  div_cnt_q <= div_cnt_q + DCNT_W'(1);
				ST_NORM: begin
					lvl_q <= lvl_q + LVL_W'(1);
					a_q   <= '0;
					b_q   <= '0;
				end
				default: ;
			endcase
		end
	end

	// outputs
	always_comb begin
		ctl            = '0;
		ctl.lvl        = lvl_q;
		ctl.a          = a_q;
		ctl.b          = b_q;
		ctl.wr_sample  = accept && (cmd == CMD_SAMPLE);
		ctl.wr_stats   = accept && (cmd == CMD_STATS);
		ctl.q_accept   = accept && (cmd == CMD_QUERY);
		ctl.q_init     = (state_q == ST_PREP);
		ctl.cell_issue = (state_q == ST_CELL0);
		ctl.pair_b     = (state_q == ST_CELL1);
		ctl.cell_fin   = (state_q == ST_CELL2);
		ctl.step_b     = (state_q == ST_CELL2) && !last_b;
		ctl.step_a     = (state_q == ST_CELL2) && last_b && !last_a;
		ctl.div_init   = (state_q == ST_DIV0);
		ctl.div_step   = (state_q == ST_DIV);
		ctl.norm       = (state_q == ST_NORM);
		ctl.lvl_next   = (state_q == ST_NORM) && !last_lvl;
		busy           = (state_q != ST_IDLE);
		done           = (state_q == ST_DONE);
	end

	// checks
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |=> state_q == ST_IDLE)
		else $error("result strobe longer than one cycle");
	a_cell_seq: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CELL0 |=> state_q == ST_CELL1 ##1 state_q == ST_CELL2)
		else $error("cell sequence broken");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && div_cnt_q != DCNT_W'(DIV_STEPS - 1)) |=> state_q == ST_DIV)
		else $error("divider left early");
	a_steps: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.step_b, ctl.step_a, ctl.lvl_next}))
		else $error("conflicting loop steps");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CELL0 |-> (a_q <= lvl_q && b_q <= lvl_q))
		else $error("cell index beyond level");

endmodule

`default_nettype wire

### rtl/hsnr_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsnr_dp
// Datapath: sample plane, level statistics, cell sum banks, divider, best.
// ----------------------------------------------------------------------------
module hsnr_dp
	import hsnr_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire hsnr_cmd_t                ctl,
	output hsnr_stat_t                    stat,
	input  wire logic [IDX_W-1:0]         index,
	input  wire logic signed [SMP_W-1:0]  sample,
	input  wire logic signed [SUM_W-1:0]  mean,
	input  wire logic [SPR_W-1:0]         spread,
	input  wire logic                     cfg_valid,
	input  wire logic [1:0]               cfg_index,
	input  wire logic [CFG_W-1:0]         cfg_data,
	output logic signed [SUM_W-1:0]       snr,
	output logic [LVL_W-1:0]              best_harmonic
);

	// configuration
	logic [CFG_W-1:0]  row_length_q, row_count_q;
	logic [LCNT_W-1:0] harm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= CFG_W'(4096);
			row_count_q  <= CFG_W'(1);
			harm_q       <= LCNT_W'(8);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ROW_LENGTH: row_length_q <= cfg_data;
				CFG_ROW_COUNT:  row_count_q  <= cfg_data;
				CFG_HARM_COUNT: harm_q       <= cfg_data[LCNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign stat.levels = (harm_q > LCNT_W'(MAX_LEVELS)) ? LCNT_W'(MAX_LEVELS) : harm_q;

	// sample plane
	logic signed [SMP_W-1:0] smem [STORE_DEPTH];
	logic signed [SMP_W-1:0] smp_rd_q;
	logic [AOFF_W-1:0]       addr;

	always_ff @(posedge clk) begin
		if (ctl.wr_sample) smem[index[ADDR_W-1:0]] <= sample;
		if (ctl.cell_issue) smp_rd_q <= smem[addr[ADDR_W-1:0]];
	end

	// level statistics
	logic signed [SUM_W-1:0] mean_q   [MAX_LEVELS];
	logic [SPR_W-1:0]        spread_q [MAX_LEVELS];

	always_ff @(posedge clk) begin
		if (ctl.wr_stats && (index[IDX_W-1:LVL_W] == '0)) begin
			mean_q[index[LVL_W-1:0]]   <= mean;
			spread_q[index[LVL_W-1:0]] <= spread;
		end
	end

	// query addressing
	logic [IDX_W-1:0]    t_q;
	logic [LIM_W-1:0]    limit_q;
	logic [BASE_W-1:0]   base_q;
	logic [ROFF_W-1:0]   roff_q;
	logic [2*CFG_W-1:0]  prod;

	assign prod = (2*CFG_W)'(row_length_q) * (2*CFG_W)'(row_count_q);
	assign addr = AOFF_W'(base_q) + AOFF_W'(ctl.a) + AOFF_W'(roff_q);

	always_ff @(posedge clk) begin
		if (ctl.q_accept) t_q <= index;
		if (ctl.q_init) begin
			limit_q <= (prod > (2*CFG_W)'(STORE_DEPTH)) ? LIM_W'(STORE_DEPTH)
			                                             : prod[LIM_W-1:0];
			base_q  <= BASE_W'(t_q);
		end else if (ctl.lvl_next) begin
			base_q  <= base_q + BASE_W'(t_q);
		end
		if (ctl.q_init || ctl.lvl_next || ctl.step_a) roff_q <= '0;
		else if (ctl.step_b) roff_q <= roff_q + ROFF_W'(row_length_q);
	end

	// cell sum banks, bank chosen by level parity
	logic signed [SUM_W-1:0] cmem [CELL_DEPTH];
	logic signed [SUM_W-1:0] crd0_q, crd1_q;
	logic [CELL_DEPTH-1:0]   ok_q;
	logic                    cur, prv;
	logic [LVL_W-1:0]        am1, bm1;
	logic [CELL_AW-1:0]      ra0, ra1, wa;
	logic                    pv0, pv1, pv0_q, pv1_q, inrange_q;

	assign cur = ctl.lvl[0];
	assign prv = ~ctl.lvl[0];
	assign am1 = ctl.a - LVL_W'(1);
	assign bm1 = ctl.b - LVL_W'(1);
	assign wa  = {cur, ctl.a, ctl.b};

	// parent pair addresses and validity
	always_comb begin
		if (ctl.pair_b) begin
			ra0 = {prv, ctl.a, bm1};
			ra1 = {prv, am1, bm1};
			pv0 = (ctl.b != '0) && (ctl.a < ctl.lvl) && ok_q[ra0];
			pv1 = (ctl.a != '0) && (ctl.b != '0) && ok_q[ra1];
		end else begin
			ra0 = {prv, ctl.a, ctl.b};
			ra1 = {prv, am1, ctl.b};
			pv0 = (ctl.a < ctl.lvl) && (ctl.b < ctl.lvl) && ok_q[ra0];
			pv1 = (ctl.a != '0) && (ctl.b < ctl.lvl) && ok_q[ra1];
		end
	end

	// best parent merge
	logic                    reach_q, reach_a, reach_b, reach_m;
	logic signed [SUM_W-1:0] psum_q, psum_a, psum_b, psum_m;
	logic                    merge_base;
	logic signed [SUM_W-1:0] merge_sum;

	assign merge_base = ctl.pair_b ? (ctl.lvl == '0) : reach_q;
	assign merge_sum  = ctl.pair_b ? '0 : psum_q;

	always_comb begin
		reach_a = merge_base;
		psum_a  = merge_sum;
		if (pv0_q && (!reach_a || crd0_q > psum_a)) psum_a = crd0_q;
		reach_a = reach_a | pv0_q;
		reach_b = reach_a;
		psum_b  = psum_a;
		if (pv1_q && (!reach_b || crd1_q > psum_b)) psum_b = crd1_q;
		reach_b = reach_b | pv1_q;
		reach_m = reach_b;
		psum_m  = psum_b;
	end

	// cell sum with saturation
	logic signed [SUM_W:0]   sum_w;
	logic signed [SUM_W-1:0] cell_sum;
	logic                    cell_ok;

	assign sum_w = {psum_m[SUM_W-1], psum_m} + (SUM_W+1)'(smp_rd_q);
	always_comb begin
		if (sum_w[SUM_W] != sum_w[SUM_W-1]) cell_sum = sum_w[SUM_W] ? SAT_MIN : SAT_MAX;
		else cell_sum = sum_w[SUM_W-1:0];
	end
	assign cell_ok = reach_m && inrange_q;

	always_ff @(posedge clk) begin
		if (ctl.cell_issue || ctl.pair_b) begin
			crd0_q <= cmem[ra0];
			crd1_q <= cmem[ra1];
			pv0_q  <= pv0;
			pv1_q  <= pv1;
		end
		if (ctl.cell_issue) inrange_q <= (addr < AOFF_W'(limit_q));
		if (ctl.pair_b) begin
			reach_q <= reach_m;
			psum_q  <= psum_m;
		end
		if (ctl.cell_fin && cell_ok) cmem[wa] <= cell_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ok_q <= '0;
		else if (ctl.cell_fin) ok_q[wa] <= cell_ok;
	end

	// level maximum
	logic signed [SUM_W-1:0] lvl_max_q;

	always_ff @(posedge clk) begin
		if (ctl.q_init || ctl.lvl_next) lvl_max_q <= '0;
		else if (ctl.cell_fin && cell_ok && (cell_sum > lvl_max_q)) lvl_max_q <= cell_sum;
	end

	// restoring divider, one quotient bit a cycle
	logic signed [DIFF_W-1:0] diff, diff_q;
	logic [DIFF_W-1:0]        mag;
	logic [NUM_W-1:0]         num_q, quo_q;
	logic [SPR_W-1:0]         rem_q, sp_cur;
	logic [SPR_W:0]           trial;
	logic                     zero_sp_q;

	assign sp_cur = spread_q[ctl.lvl];
	assign diff   = DIFF_W'(lvl_max_q) - DIFF_W'(mean_q[ctl.lvl]);
	assign mag    = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
	assign trial  = {rem_q, num_q[NUM_W-1]};

	always_ff @(posedge clk) begin
		if (ctl.div_init) begin
			diff_q    <= diff;
			zero_sp_q <= (sp_cur == '0);
			num_q     <= {mag, 8'b0};
			rem_q     <= '0;
			quo_q     <= '0;
		end else if (ctl.div_step) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			if (trial >= {1'b0, sp_cur}) begin
				rem_q <= SPR_W'(trial - {1'b0, sp_cur});
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[SPR_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	// normalised value and running best
	logic signed [SUM_W-1:0] norm_v, best_q;
	logic [LVL_W-1:0]        bpos_q;
	logic                    q_big;

	assign q_big = (quo_q[NUM_W-1:SUM_W-1] != '0);

	always_comb begin
		if (zero_sp_q) begin
			if (diff_q == '0) norm_v = '0;
			else norm_v = diff_q[DIFF_W-1] ? SAT_MIN : SAT_MAX;
		end else if (diff_q[DIFF_W-1]) begin
			norm_v = q_big ? SAT_MIN : -SUM_W'(quo_q[SUM_W-2:0]);
		end else begin
			norm_v = q_big ? SAT_MAX : SUM_W'(quo_q[SUM_W-2:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.q_init) begin
			best_q <= '0;
			bpos_q <= '0;
		end else if (ctl.norm && ((ctl.lvl == '0) || (norm_v > best_q))) begin
			best_q <= norm_v;
			bpos_q <= ctl.lvl;
		end
	end

	assign snr           = best_q;
	assign best_harmonic = bpos_q;

endmodule

`default_nettype wire

### sim/hsnr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsnr_checker
// Watches the command, configuration and result channels of the harmonic sum
// block, keeps its own copy of the stores and registers, works out the snr and
// best level of every query and compares each result beat against it.
// ----------------------------------------------------------------------------
module hsnr_checker
	import hsnr_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    busy,
	input  logic [1:0]              cmd,
	input  logic [IDX_W-1:0]        index,
	input  logic signed [SMP_W-1:0] sample,
	input  logic signed [SUM_W-1:0] mean,
	input  logic [SPR_W-1:0]        spread,
	input  logic                    done,
	input  logic signed [SUM_W-1:0] snr,
	input  logic [LVL_W-1:0]        best_harmonic,
	input  logic                    cfg_valid,
	input  logic                    cfg_ready,
	input  logic [1:0]              cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	output int                      errors,
	output int                      pending
);

	typedef struct packed {
		logic signed [SUM_W-1:0] snr;
		logic [LVL_W-1:0]        lvl;
	} query_res_t;

	logic signed [SMP_W-1:0] plane [STORE_DEPTH];
	logic signed [SUM_W-1:0] lvl_mean [MAX_LEVELS];
	logic [SPR_W-1:0]        lvl_spread [MAX_LEVELS];
	logic [CFG_W-1:0]        row_len, row_cnt;
	logic [3:0]              harm_cnt;
	query_res_t              awaited [$];

	// (max - mean) / spread in q16.8, saturating
	function automatic longint snr_of(longint maxv, longint mu, longint sd);
		longint diff, mag, q;
		diff = maxv - mu;
		if (sd == 0) begin
			if (diff > 0) return 64'sd8388607;
			if (diff < 0) return -64'sd8388608;
			return 0;
		end
		mag = (diff < 0) ? -diff : diff;
		q = (mag * 256) / sd;
		if (diff < 0) return (q > 8388608) ? -64'sd8388608 : -q;
		return (q > 8388607) ? 64'sd8388607 : q;
	endfunction

	// dynamic program over the level grids, then pick the best level
	function automatic query_res_t harmonic_query(longint t);
		longint     sums [2][MAX_LEVELS][MAX_LEVELS];
		bit         ok [2][MAX_LEVELS][MAX_LEVELS];
		longint     lvl_max [MAX_LEVELS];
		longint     lim, addr, psum, s, v, best;
		int         levels, cur, prv, pa, pb, best_d;
		bit         reach;
		query_res_t r;
		lim = longint'(row_len) * longint'(row_cnt);
		if (lim > STORE_DEPTH) lim = STORE_DEPTH;
		levels = (harm_cnt > MAX_LEVELS) ? MAX_LEVELS : harm_cnt;
		cur = 0;
		prv = 1;
		foreach (lvl_max[i]) lvl_max[i] = 0;
		foreach (ok[i, j, k]) ok[i][j][k] = 0;
		for (int d = 0; d < levels; d++) begin
			for (int a = 0; a <= d; a++) begin
				for (int b = 0; b <= d; b++) begin
					reach = (d == 0);
					psum = 0;
					if (d > 0) begin
						for (int da = 0; da < 2; da++) begin
							for (int db = 0; db < 2; db++) begin
								pa = a - da;
								pb = b - db;
								if (pa >= 0 && pb >= 0 && pa < d && pb < d && ok[prv][pa][pb]) begin
									if (!reach || sums[prv][pa][pb] > psum)
										psum = sums[prv][pa][pb];
									reach = 1;
								end
							end
						end
					end
					addr = longint'(d + 1) * t + a + longint'(b) * row_len;
					if (reach && addr < lim) begin
						s = psum + plane[addr];
						if (s > 8388607) s = 8388607;
						if (s < -8388608) s = -8388608;
						sums[cur][a][b] = s;
						ok[cur][a][b] = 1;
						if (s > lvl_max[d]) lvl_max[d] = s;
					end else begin
						ok[cur][a][b] = 0;
					end
				end
			end
			cur ^= 1;
			prv ^= 1;
		end
		best = 0;
		best_d = 0;
		for (int d = 0; d < levels; d++) begin
			v = snr_of(lvl_max[d], lvl_mean[d], lvl_spread[d]);
			if (d == 0 || v > best) begin
				best = v;
				best_d = d;
			end
		end
		r.snr = best[SUM_W-1:0];
		r.lvl = best_d[LVL_W-1:0];
		return r;
	endfunction

	// register writes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_len  <= 13'd4096;
			row_cnt  <= 13'd1;
			harm_cnt <= 4'd8;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ROW_LENGTH: row_len <= cfg_data;
				CFG_ROW_COUNT:  row_cnt <= cfg_data;
				CFG_HARM_COUNT: harm_cnt <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// result beats against the oldest prediction, then new command beats
	initial errors = 0;
	initial pending = 0;
	always @(posedge clk) begin
		query_res_t exp_r;
		if (arst_n && done) begin
			if (awaited.size() == 0) begin
				$display("%0t: unexpected result snr=%0d level=%0d", $time, snr, best_harmonic);
				errors++;
			end else begin
				exp_r = awaited.pop_front();
				if (snr !== exp_r.snr) begin
					$display("%0t: snr expected %0d actual %0d", $time, exp_r.snr, snr);
					errors++;
				end
				if (best_harmonic !== exp_r.lvl) begin
					$display("%0t: best_harmonic expected %0d actual %0d",
						$time, exp_r.lvl, best_harmonic);
					errors++;
				end
			end
		end
		if (arst_n && start && !busy) begin
			case (cmd)
				CMD_SAMPLE: plane[index] = sample;
				CMD_STATS: begin
					if (index < MAX_LEVELS) begin
						lvl_mean[index[LVL_W-1:0]]   = mean;
						lvl_spread[index[LVL_W-1:0]] = spread;
					end
				end
				CMD_QUERY: awaited.push_back(harmonic_query(longint'(index)));
				default: ;
			endcase
		end
		pending = awaited.size();
	end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the harmonic sum block through several plane shapes and level
// counts: a load of the low part of the plane, directed extremes, then
// random bursts of loads and queries. The checker beside the block scores
// every result.
// ----------------------------------------------------------------------------
module tb;
	import hsnr_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	// samples loaded at the start; plane_lim bounds most query positions and sample writes to them
	localparam int PLANE_LOADED = 128;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [1:0]              cmd;
	logic [IDX_W-1:0]        index;
	logic signed [SMP_W-1:0] sample;
	logic signed [SUM_W-1:0] mean;
	logic [SPR_W-1:0]        spread;
	logic                    done;
	logic signed [SUM_W-1:0] snr;
	logic [LVL_W-1:0]        best_harmonic;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [1:0]              cfg_index;
	logic [CFG_W-1:0]        cfg_data;
	int                      errors;
	int                      pending;
	int                      plane_lim;
	int                      burst_left;
	int                      rl_pick;

	two_d_harmonic_sum_snr dut (.*);
	hsnr_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#200_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// one command beat; busy is steady from the falling edge to the next rising one
	task automatic issue(input logic [1:0] c, input int idx, input int smp,
			input int mu, input int sd, input bit paced);
		if (paced) begin
			if (burst_left == 0) begin
				start = 1'b0;
				if ($urandom_range(0, 3) != 0)
					repeat ($urandom_range(1, 12)) @(negedge clk);
				burst_left = $urandom_range(1, 24);
			end
			burst_left--;
		end
		start  = 1'b1;
		cmd    = c;
		index  = idx[IDX_W-1:0];
		sample = smp[SMP_W-1:0];
		mean   = mu[SUM_W-1:0];
		spread = sd[SPR_W-1:0];
		while (busy) @(negedge clk);
		@(negedge clk);
		if (!paced) start = 1'b0;
	endtask

	task automatic drain();
		start = 1'b0;
		while (pending != 0 || busy) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] ri, input int val);
		cfg_valid = 1'b1;
		cfg_index = ri;
		cfg_data  = val[CFG_W-1:0];
		while (!cfg_ready) @(negedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_shape(input int rl, input int rc, input int hc);
		drain();
		write_reg(CFG_ROW_LENGTH, rl);
		write_reg(CFG_ROW_COUNT, rc);
		write_reg(CFG_HARM_COUNT, hc);
		plane_lim = (rl * rc > PLANE_LOADED) ? PLANE_LOADED : rl * rc;
	endtask

	// query position, mostly where the deeper levels still land in the plane
	function automatic int pick_pos();
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 4095);
			1, 2: return $urandom_range(0, 3);
			default: return $urandom_range(0, (plane_lim / 9 > 0) ? plane_lim / 9 : 0);
		endcase
	endfunction

	function automatic int rand_sample();
		case ($urandom_range(0, 7))
			0: return -32768;
			1: return 32767;
			default: return $signed($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	task automatic random_items(input int n);
		int u;
		for (int i = 0; i < n; i++) begin
			u = $urandom_range(0, 99);
			if (u < 40)
				issue(CMD_QUERY, pick_pos(), 0, 0, 0, 1);
			else if (u < 85)
				issue(CMD_SAMPLE, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
					: $urandom_range(0, plane_lim - 1), rand_sample(), 0, 0, 1);
			else if (u < 95)
				issue(CMD_STATS, $urandom_range(0, 7), 0,
					$signed($urandom_range(0, 24'hFFFF)) - 24'sd32768,
					($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24'h7FFFFF >> $urandom_range(0, 22)),
					1);
			else if (u < 98)
				issue(CMD_STATS, $urandom_range(8, 4095), 0, $urandom, $urandom, 1);
			else
				issue(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom, 1);
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		cmd        = CMD_SAMPLE;
		index      = '0;
		sample     = '0;
		mean       = '0;
		spread     = '0;
		cfg_valid  = 1'b0;
		cfg_index  = CFG_ROW_LENGTH;
		cfg_data   = '0;
		burst_left = 0;
		rl_pick    = 1;
		plane_lim  = PLANE_LOADED;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// low part of the plane and every level's statistics before any query reads them
		for (int i = 0; i < PLANE_LOADED; i++)
			issue(CMD_SAMPLE, i, rand_sample(), 0, 0, 0);
		for (int i = 0; i < MAX_LEVELS; i++)
			issue(CMD_STATS, i, 0, $urandom_range(0, 2000), $urandom_range(1, 4000), 0);
		set_shape(PLANE_LOADED, 1, 8);

		// directed: stats extremes, zero spread, ignored commands, edge samples and queries
		issue(CMD_STATS, 0, 0, -8388608, 0, 0);
		issue(CMD_STATS, 1, 0, 8388607, 0, 0);
		issue(CMD_STATS, 2, 0, 0, 1, 0);
		issue(CMD_STATS, 3, 0, 123, 8388607, 0);
		issue(CMD_STATS, 7, 0, -5000, 1, 0);
		issue(CMD_STATS, 4095, 0, 77, 77, 0);
		issue(CMD_UNUSED, 4095, -1, -1, -1, 0);
		issue(CMD_SAMPLE, 0, 32767, 0, 0, 0);
		issue(CMD_SAMPLE, 4095, -32768, 0, 0, 0);
		issue(CMD_QUERY, 0, 0, 0, 0, 0);
		issue(CMD_QUERY, 4095, 0, 0, 0, 0);
		issue(CMD_QUERY, 1, 0, 0, 0, 0);
		issue(CMD_QUERY, 2048, 0, 0, 0, 0);
		issue(CMD_STATS, 0, 0, 0, 0, 0);
		issue(CMD_STATS, 1, 0, 8388607, 8388607, 0);
		issue(CMD_QUERY, 0, 0, 0, 0, 0);
		issue(CMD_QUERY, 100, 0, 0, 0, 0);

		random_items(120);
		set_shape(1, PLANE_LOADED, 8);
		issue(CMD_QUERY, 0, 0, 0, 0, 0);
		issue(CMD_QUERY, 4095, 0, 0, 0, 0);
		random_items(110);
		set_shape(16, 8, 12);
		random_items(110);
		set_shape(1, 1, 1);
		issue(CMD_QUERY, 0, 0, 0, 0, 0);
		issue(CMD_QUERY, 1, 0, 0, 0, 0);
		random_items(60);
		set_shape(13, 7, 5);
		random_items(110);
		rl_pick = $urandom_range(1, PLANE_LOADED);
		set_shape(rl_pick, $urandom_range(1, PLANE_LOADED / rl_pick), $urandom_range(1, 8));
		random_items(110);

		// row product beyond the store: only the first row lands in it
		set_shape(4096, 4096, 3);
		issue(CMD_QUERY, 0, 0, 0, 0, 0);
		issue(CMD_QUERY, 5, 0, 0, 0, 0);
		issue(CMD_QUERY, 41, 0, 0, 0, 0);
		issue(CMD_QUERY, 4095, 0, 0, 0, 0);

		// no levels at all
		set_shape(PLANE_LOADED, 1, 0);
		issue(CMD_QUERY, 3, 0, 0, 0, 0);

		set_shape(PLANE_LOADED, 1, 8);
		random_items(60);

		drain();
		repeat (900) @(negedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
